// File: design/eme_pkg.sv
// shared types, register indexes, reset values and saturation helpers of the motion estimator
`default_nettype none

package eme_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_WORD     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POSITION_SHIFT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_VELOCITY_SHIFT = 2'd2;

    // register widths and reset values
    localparam int CFG_DATA_W = 32;
    localparam int SHIFT_W    = 5;
    localparam logic [CFG_DATA_W-1:0] SCALE_WORD_RESET     = 32'h0000_8000;
    localparam logic [SHIFT_W-1:0]    POSITION_SHIFT_RESET = 5'd4;
    localparam logic [SHIFT_W-1:0]    VELOCITY_SHIFT_RESET = 5'd6;

    // stream widths
    localparam int COUNT_W   = 16;
    localparam int SAMPLE_W  = 16;
    localparam int ACC_W     = 32;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 64;

    // fractional bits of the lower scale half
    localparam int Q15_SHIFT = 15;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_in;    // capture count reading, form wrapped difference
        logic mul_hi;     // signed upper scale half times sample
        logic mul_lo;     // unsigned lower scale half times sample
        logic scale;      // combine products and saturate
        logic acc;        // add sample into accumulator
        logic leak;       // leak accumulator, form filter output
        logic vdiff;      // difference of successive smooth positions
        logic out_load;   // move results into the output register
        logic vel;        // working on the velocity path
    } eme_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_free;   // output register can take a new result
    } eme_status_t;

    // saturate a 34-bit signed value to 16 bits
    function automatic logic [15:0] sat16_from34(input logic [33:0] v);
        logic [18:0] ext;
        ext = {19{v[33]}};
        if (v[33:15] == ext) begin
            return v[15:0];
        end
        return v[33] ? 16'h8000 : 16'h7fff;
    endfunction

    // saturate a 32-bit signed value to 16 bits
    function automatic logic [15:0] sat16_from32(input logic [31:0] v);
        logic [16:0] ext;
        ext = {17{v[31]}};
        if (v[31:15] == ext) begin
            return v[15:0];
        end
        return v[31] ? 16'h8000 : 16'h7fff;
    endfunction

    // saturate a 17-bit signed value to 16 bits
    function automatic logic [15:0] sat16_from17(input logic [16:0] v);
        if (v[16] == v[15]) begin
            return v[15:0];
        end
        return v[16] ? 16'h8000 : 16'h7fff;
    endfunction

    // saturate a 33-bit signed value to 32 bits
    function automatic logic [31:0] sat32_from33(input logic [32:0] v);
        if (v[32] == v[31]) begin
            return v[31:0];
        end
        return v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    endfunction

endpackage

`default_nettype wire

// File: design/eme_ctrl.sv
// sequencer that steps the shared multiplier and filter datapath through one item
`default_nettype none

module eme_ctrl
    import eme_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire eme_status_t status,
    output eme_cmd_t         cmd
);

    // state codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL_HI = 3'd1;
    localparam logic [2:0] ST_MUL_LO = 3'd2;
    localparam logic [2:0] ST_SCALE  = 3'd3;
    localparam logic [2:0] ST_ACC    = 3'd4;
    localparam logic [2:0] ST_LEAK   = 3'd5;
    localparam logic [2:0] ST_VDIFF  = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       vel_reg, vel_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // next state and datapath commands
    always_comb begin
        state_next   = state_reg;
        vel_next     = vel_reg;
        cmd          = '0;
        cmd.vel      = vel_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.load_in = accept;
                if (accept) begin
                    vel_next   = 1'b0;
                    state_next = ST_MUL_HI;
                end
            end
            ST_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = ST_LEAK;
            end
            ST_LEAK: begin
                cmd.leak   = 1'b1;
                state_next = vel_reg ? ST_DONE : ST_VDIFF;
            end
            ST_VDIFF: begin
                cmd.vdiff  = 1'b1;
                vel_next   = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            vel_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            vel_reg   <= vel_next;
        end
    end

endmodule

`default_nettype wire

// File: design/eme_datapath.sv
// configuration registers, shared scale multiplier, leaky filters and output register
`default_nettype none

module eme_datapath
    import eme_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata,
    input  wire eme_cmd_t               cmd,
    output eme_status_t                 status
);

    // configuration
    logic [CFG_DATA_W-1:0] scale_word_reg;
    logic [SHIFT_W-1:0]    position_shift_reg;
    logic [SHIFT_W-1:0]    velocity_shift_reg;

    // item state
    logic [COUNT_W-1:0]        last_count_reg;
    logic signed [SAMPLE_W-1:0] last_smooth_reg;
    logic signed [ACC_W-1:0]   pos_acc_reg;
    logic signed [ACC_W-1:0]   vel_acc_reg;

    // working registers
    logic signed [SAMPLE_W-1:0] diff_reg;
    logic signed [32:0]        ph_reg;
    logic signed [32:0]        pl_reg;
    logic signed [ACC_W-1:0]   a_reg;
    logic [SAMPLE_W-1:0]       raw_pos_reg;
    logic [SAMPLE_W-1:0]       smooth_pos_reg;
    logic [SAMPLE_W-1:0]       raw_vel_reg;
    logic [SAMPLE_W-1:0]       smooth_vel_reg;

    // output register
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    // shared multiplier operands and combined terms
    logic signed [16:0]        mul_a;
    logic signed [32:0]        mul_p;
    logic signed [32:0]        pl_shift;
    logic signed [33:0]        scale_sum;
    logic [SAMPLE_W-1:0]       scaled;
    logic signed [SAMPLE_W-1:0] x_sel;
    logic signed [ACC_W-1:0]   acc_sel;
    logic signed [32:0]        acc_sum;
    logic [SHIFT_W-1:0]        shift_sel;
    logic signed [ACC_W-1:0]   leak_y;
    logic signed [32:0]        leak_rem;
    logic [ACC_W-1:0]          acc_new;
    logic [SAMPLE_W-1:0]       y16;
    logic signed [16:0]        vd_sum;

    assign mul_a = cmd.mul_hi ? $signed({scale_word_reg[31], scale_word_reg[31:16]})
                              : $signed({1'b0, scale_word_reg[15:0]});
    assign mul_p = mul_a * diff_reg;

    // upper*2*x plus lower*x shifted down by the fraction bits
    assign pl_shift  = pl_reg >>> Q15_SHIFT;
    assign scale_sum = $signed({ph_reg, 1'b0}) + $signed({pl_shift[32], pl_shift});
    assign scaled    = sat16_from34(scale_sum);

    // filter path selection
    assign x_sel     = cmd.vel ? $signed(raw_vel_reg) : $signed(raw_pos_reg);
    assign acc_sel   = cmd.vel ? vel_acc_reg : pos_acc_reg;
    assign shift_sel = cmd.vel ? velocity_shift_reg : position_shift_reg;
    assign acc_sum   = $signed({acc_sel[31], acc_sel}) + $signed({{17{x_sel[15]}}, x_sel});

    // leak step
    assign leak_y   = a_reg >>> shift_sel;
    assign leak_rem = $signed({a_reg[31], a_reg}) - $signed({leak_y[31], leak_y});
    assign acc_new  = sat32_from33(leak_rem);
    assign y16      = sat16_from32(leak_y);

    // velocity input difference
    assign vd_sum = $signed({smooth_pos_reg[15], smooth_pos_reg})
                  - $signed({last_smooth_reg[15], last_smooth_reg});

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_word_reg     <= SCALE_WORD_RESET;
            position_shift_reg <= POSITION_SHIFT_RESET;
            velocity_shift_reg <= VELOCITY_SHIFT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SCALE_WORD:     scale_word_reg     <= cfg_wdata;
                CFG_POSITION_SHIFT: position_shift_reg <= cfg_wdata[SHIFT_W-1:0];
                CFG_VELOCITY_SHIFT: velocity_shift_reg <= cfg_wdata[SHIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // history and accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_count_reg  <= '0;
            last_smooth_reg <= '0;
            pos_acc_reg     <= '0;
            vel_acc_reg     <= '0;
        end else begin
            if (cmd.load_in) begin
                last_count_reg <= s_tdata[COUNT_W-1:0];
            end
            if (cmd.vdiff) begin
                last_smooth_reg <= smooth_pos_reg;
            end
            if (cmd.leak) begin
                if (cmd.vel) begin
                    vel_acc_reg <= acc_new;
                end else begin
                    pos_acc_reg <= acc_new;
                end
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            diff_reg <= s_tdata[COUNT_W-1:0] - last_count_reg;
        end
        if (cmd.vdiff) begin
            diff_reg <= sat16_from17(vd_sum);
        end
        if (cmd.mul_hi) begin
            ph_reg <= mul_p;
        end
        if (cmd.mul_lo) begin
            pl_reg <= mul_p;
        end
        if (cmd.scale) begin
            if (cmd.vel) begin
                raw_vel_reg <= scaled;
            end else begin
                raw_pos_reg <= scaled;
            end
        end
        if (cmd.acc) begin
            a_reg <= sat32_from33(acc_sum);
        end
        if (cmd.leak) begin
            if (cmd.vel) begin
                smooth_vel_reg <= y16;
            end else begin
                smooth_pos_reg <= y16;
            end
        end
    end

    // output register, holds a result until the transaction completes
    assign status.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= {smooth_vel_reg, raw_vel_reg, smooth_pos_reg, raw_pos_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: design/encoder_motion_estimator.sv
// top level of the encoder motion estimator: position and velocity deltas per counter reading
//
// channel   direction  payload
// s_*       in         count_reading
// m_*       out        raw/smooth position delta, raw/smooth velocity delta
// cfg_*     in         register writes: scale_word, position_shift, velocity_shift
//
// the sequencer steps an item from its acceptance to its result entering the output register,
// paced by the single shared 17x16 multiplier: each of the two scale steps uses it twice,
// followed by a saturate, an accumulate and a leak step per filter, plus a velocity
// difference step between the passes and a load step that waits for a free output register.
// a new reading is accepted no sooner than the cycle after the result is loaded.
// reset (aresetn low, synchronous) clears histories and accumulators, loads register defaults.
// a stalled output holds its transaction; the sequencer waits only to reload it.
`default_nettype none

module encoder_motion_estimator
    import eme_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    // input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,   // [15:0] count_reading
    // result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata    // [15:0] raw_position_delta,
                                                   // [31:16] smooth_position_delta,
                                                   // [47:32] raw_velocity_delta,
                                                   // [63:48] smooth_velocity_delta
);

    eme_cmd_t    cmd;
    eme_status_t status;

    // sequencer
    eme_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and storage
    eme_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire
